// ===== hdl/dpbs_pkg.sv =====
// ============================================================================
// dpbs_pkg: shared types and constants for the double power-by-squaring core
// Beat types, unit opcodes, state encodings and IEEE double constants.
// ============================================================================
package dpbs_pkg;

    // Default width of the exponent that is actually used.
    localparam int DPBS_EXP_WIDTH = 32;

    // IEEE 754 double constants.
    localparam logic [63:0] DBL_ONE         = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] DBL_EXP_MAX     = 11'h7FF;

    // Exponent arithmetic inside the unit is signed and 14 bits wide.
    localparam int EXPW = 14;

    // One input beat and one result beat.
    typedef struct packed {
        logic [63:0]        base_bits;
        logic signed [31:0] exponent;
    } dpbs_in_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        undefined;
    } dpbs_out_t;

    // Operations of the shared floating-point unit.
    typedef enum logic {
        FOP_MUL,
        FOP_RECIP
    } fop_t;

    typedef struct packed {
        logic valid;
        fop_t op;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] bits;
    } fpu_rsp_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_MUL,
        F_DIV,
        F_ALIGN,
        F_DENORM,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_SCAN,
        T_LEVEL,
        T_WAIT_U,
        T_SQR,
        T_WAIT_F,
        T_FINISH,
        T_WAIT_R
    } top_state_t;

endpackage

// ===== hdl/dpbs_fpu.sv =====
// ============================================================================
// dpbs_fpu: multi-cycle IEEE double multiplier and reciprocal unit
// Round to nearest even, full subnormal support, one operation at a time.
// ============================================================================
module dpbs_fpu (
    input  logic               clk,
    input  logic               rst_n,
    input  dpbs_pkg::fpu_req_t req,
    input  logic [63:0]        opa,
    input  logic [63:0]        opb,
    output dpbs_pkg::fpu_rsp_t rsp
);
    import dpbs_pkg::*;

    fpu_state_t             state_reg, state_next;
    fop_t                   op_reg;
    logic                   sign_reg;
    logic [52:0]            siga_reg, sigb_reg;
    logic signed [EXPW-1:0] expa_reg, expb_reg;
    logic signed [EXPW-1:0] e_reg;
    logic signed [EXPW-1:0] be_reg;
    logic [105:0]           p_reg;
    logic                   stk_reg;
    logic [5:0]             cnt_reg;
    logic [53:0]            rem_reg;
    logic [63:0]            res_reg;

    // Operand classification.
    logic [10:0] ea, eb;
    logic [51:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        special;
    logic [63:0] special_bits;
    logic        res_sign;

    assign ea     = opa[62:52];
    assign eb     = opb[62:52];
    assign fa     = opa[51:0];
    assign fb     = opb[51:0];
    assign a_nan  = (ea == DBL_EXP_MAX) && (fa != '0);
    assign b_nan  = (eb == DBL_EXP_MAX) && (fb != '0);
    assign a_inf  = (ea == DBL_EXP_MAX) && (fa == '0);
    assign b_inf  = (eb == DBL_EXP_MAX) && (fb == '0);
    assign a_zero = (ea == '0) && (fa == '0);
    assign b_zero = (eb == '0) && (fb == '0);

    always_comb
    begin
        res_sign     = (req.op == FOP_MUL) ? (opa[63] ^ opb[63]) : opa[63];
        special      = 1'b1;
        special_bits = '0;
        if (req.op == FOP_MUL)
        begin
            priority if (a_nan)
                special_bits = opa | (64'd1 << 51);
            else if (b_nan)
                special_bits = opb | (64'd1 << 51);
            else if ((a_inf && b_zero) || (a_zero && b_inf))
                special_bits = DBL_DEFAULT_NAN;
            else if (a_inf || b_inf)
                special_bits = {res_sign, DBL_EXP_MAX, 52'd0};
            else if (a_zero || b_zero)
                special_bits = {res_sign, 63'd0};
            else
                special = 1'b0;
        end
        else
        begin
            priority if (a_nan)
                special_bits = opa | (64'd1 << 51);
            else if (a_inf)
                special_bits = {res_sign, 63'd0};
            else if (a_zero)
                special_bits = {res_sign, DBL_EXP_MAX, 52'd0};
            else
                special = 1'b0;
        end
    end

    // One 27x27 partial product per cycle into the 106-bit accumulator.
    logic [26:0]  mul_x, mul_y;
    logic [53:0]  mul_p;
    logic [105:0] mul_sh;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                mul_x = siga_reg[26:0];
                mul_y = sigb_reg[26:0];
            end
            2'd1:
            begin
                mul_x = siga_reg[26:0];
                mul_y = {1'b0, sigb_reg[52:27]};
            end
            2'd2:
            begin
                mul_x = {1'b0, siga_reg[52:27]};
                mul_y = sigb_reg[26:0];
            end
            default:
            begin
                mul_x = {1'b0, siga_reg[52:27]};
                mul_y = {1'b0, sigb_reg[52:27]};
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    mul_sh = {52'd0, mul_p};
            2'd1:    mul_sh = {25'd0, mul_p, 27'd0};
            2'd2:    mul_sh = {25'd0, mul_p, 27'd0};
            default: mul_sh = {mul_p[51:0], 54'd0};
        endcase
    end

    // Restoring division step for the reciprocal, one quotient bit per cycle.
    logic        div_ge;
    logic [53:0] div_sel;
    logic [53:0] rem_step;

    assign div_ge   = rem_reg >= {1'b0, siga_reg};
    assign div_sel  = div_ge ? (rem_reg - {1'b0, siga_reg}) : rem_reg;
    assign rem_step = {div_sel[52:0], 1'b0};

    // Alignment and rounding.
    logic signed [EXPW-1:0] e_adj;
    logic [52:0]            mant;
    logic                   g_bit, s_bit, inc;
    logic [53:0]            mant_r;
    logic signed [EXPW-1:0] be_r;
    logic [51:0]            frac_r;
    logic [10:0]            fexp_r;

    assign e_adj  = p_reg[105] ? e_reg : (e_reg - EXPW'(1));
    assign mant   = p_reg[105:53];
    assign g_bit  = p_reg[52];
    assign s_bit  = (p_reg[51:0] != '0) || stk_reg;
    assign inc    = g_bit && (s_bit || mant[0]);
    assign mant_r = {1'b0, mant} + {53'd0, inc};
    assign be_r   = mant_r[53] ? (be_reg + EXPW'(1)) : be_reg;
    assign frac_r = mant_r[53] ? mant_r[52:1] : mant_r[51:0];
    assign fexp_r = (mant_r[53] || mant_r[52]) ? be_r[10:0] : 11'd0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
                if (req.valid)
                    state_next = special ? F_DONE : F_NORM;
            F_NORM:
                if (siga_reg[52] && sigb_reg[52])
                    state_next = (op_reg == FOP_MUL) ? F_MUL : F_DIV;
            F_MUL:
                if (cnt_reg[1:0] == 2'd3)
                    state_next = F_ALIGN;
            F_DIV:
                if (cnt_reg == 6'd55)
                    state_next = F_ALIGN;
            F_ALIGN:
                state_next = F_DENORM;
            F_DENORM:
                priority if (be_reg >= EXPW'(2047))
                    state_next = F_DONE;
                else if (be_reg >= EXPW'(1))
                    state_next = F_ROUND;
                else
                    state_next = F_DENORM;
            F_ROUND:
                state_next = F_DONE;
            default:
                state_next = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        rsp.done = (state_reg == F_DONE);
        rsp.bits = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
                if (req.valid)
                begin
                    op_reg   <= req.op;
                    sign_reg <= res_sign;
                    res_reg  <= special_bits;
                    siga_reg <= {(ea != '0), fa};
                    expa_reg <= (ea == '0) ? -EXPW'(1074)
                                           : ($signed({3'b000, ea}) - EXPW'(1075));
                    if (req.op == FOP_MUL)
                    begin
                        sigb_reg <= {(eb != '0), fb};
                        expb_reg <= (eb == '0) ? -EXPW'(1074)
                                               : ($signed({3'b000, eb}) - EXPW'(1075));
                    end
                    else
                    begin
                        sigb_reg <= {1'b1, 52'd0};
                        expb_reg <= '0;
                    end
                end
            F_NORM:
            begin
                if (!siga_reg[52])
                begin
                    siga_reg <= {siga_reg[51:0], 1'b0};
                    expa_reg <= expa_reg - EXPW'(1);
                end
                if (!sigb_reg[52])
                begin
                    sigb_reg <= {sigb_reg[51:0], 1'b0};
                    expb_reg <= expb_reg - EXPW'(1);
                end
                p_reg   <= '0;
                cnt_reg <= '0;
                stk_reg <= 1'b0;
                rem_reg <= 54'd1 << 52;
            end
            F_MUL:
            begin
                p_reg   <= p_reg + mul_sh;
                cnt_reg <= cnt_reg + 6'd1;
                e_reg   <= expa_reg + expb_reg;
            end
            F_DIV:
            begin
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd55)
                begin
                    p_reg   <= {p_reg[54:0], div_ge, 50'd0};
                    stk_reg <= (rem_step != '0);
                end
                else
                begin
                    p_reg <= {p_reg[104:0], div_ge};
                end
                e_reg <= -EXPW'(157) - expa_reg;
            end
            F_ALIGN:
            begin
                if (!p_reg[105])
                    p_reg <= {p_reg[104:0], 1'b0};
                be_reg <= e_adj + EXPW'(1128);
            end
            F_DENORM:
                priority if (be_reg >= EXPW'(2047))
                    res_reg <= {sign_reg, DBL_EXP_MAX, 52'd0};
                else if (be_reg < -EXPW'(60))
                begin
                    p_reg   <= '0;
                    stk_reg <= 1'b1;
                    be_reg  <= EXPW'(1);
                end
                else if (be_reg < EXPW'(1))
                begin
                    p_reg   <= {1'b0, p_reg[105:1]};
                    stk_reg <= stk_reg | p_reg[0];
                    be_reg  <= be_reg + EXPW'(1);
                end
            F_ROUND:
                if (be_r >= EXPW'(2047))
                    res_reg <= {sign_reg, DBL_EXP_MAX, 52'd0};
                else
                    res_reg <= {sign_reg, fexp_r, frac_r};
            default:
            begin
            end
        endcase
    end

    // The completion strobe is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("unit completion held for more than one cycle");

    // A new operation is only issued while the unit is idle.
    a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> (state_reg == F_IDLE))
        else $error("operation issued to a busy unit");

    // The sequencer always holds a known state out of reset.
    a_state_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(state_reg))
        else $error("unit state is unknown");

endmodule

// ===== hdl/double_power_by_squaring_core.sv =====
// ============================================================================
// double_power_by_squaring_core: IEEE double raised to a signed integer power
// Repeated squaring on one shared multiplier, then an optional reciprocal.
// ============================================================================
//
//  Channel | Ports            | Handshake
//  --------+------------------+-------------------------------------------
//  input   | args             | beat taken when start is high, busy low
//  result  | res              | beat shown for one cycle while done is high
//
// Each beat walks a squaring chain of depth D (at most EXP_WIDTH) on the
// shared unit, then takes a reciprocal for a negative exponent; subnormal
// values need extra normalizing or denormalizing steps in the unit. Every
// multiplication accumulates 27x27 partial products, and the reciprocal
// runs a restoring division. A zero base with a non-positive exponent is
// flagged undefined straight from idle. Reset clears the sequencers only.
// The receiver cannot stall: each result beat appears once, for one cycle.
//
module double_power_by_squaring_core #(
    parameter int EXP_WIDTH = dpbs_pkg::DPBS_EXP_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dpbs_pkg::dpbs_in_t  args,
    output logic                done,
    output dpbs_pkg::dpbs_out_t res
);
    import dpbs_pkg::*;

    localparam int DW = $clog2(EXP_WIDTH + 1);

    top_state_t           state_reg, state_next;
    logic [EXP_WIDTH-1:0] n_reg;
    logic [EXP_WIDTH-1:0] par_reg;
    logic [DW-1:0]        depth_reg;
    logic                 neg_reg;
    logic [63:0]          x_reg, f_reg, u_reg;
    logic                 done_reg;
    dpbs_out_t            res_reg;

    // The exponent field is sign-extended, then cut to the working width.
    logic [63:0]          exp_ext;
    logic [EXP_WIDTH-1:0] e_w;
    logic                 e_neg, e_zero, zero_base, undef;
    logic [EXP_WIDTH-1:0] mag;

    assign exp_ext   = {{32{args.exponent[31]}}, args.exponent};
    assign e_w       = exp_ext[EXP_WIDTH-1:0];
    assign e_neg     = e_w[EXP_WIDTH-1];
    assign e_zero    = (e_w == '0);
    assign mag       = e_neg ? (~e_w + {{(EXP_WIDTH-1){1'b0}}, 1'b1}) : e_w;
    assign zero_base = (args.base_bits[62:0] == '0);
    assign undef     = zero_base && (e_neg || e_zero);

    // Each level of the chain records its parity. An odd n leads to
    // (n-1)/2 and an even n to n/2-1; the recursion then unwinds from the
    // deepest level, so the last parity pushed is the first one used.
    logic [EXP_WIDTH-1:0] n_half, n_step;

    assign n_half = {1'b0, n_reg[EXP_WIDTH-1:1]};
    assign n_step = n_reg[0] ? n_half : (n_half - {{(EXP_WIDTH-1){1'b0}}, 1'b1});

    logic f_zero;
    assign f_zero = (f_reg[62:0] == '0);

    // Shared floating-point unit.
    fpu_req_t    fpu_req;
    logic [63:0] fpu_a, fpu_b;
    fpu_rsp_t    fpu_rsp;

    dpbs_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .opa   (fpu_a),
        .opb   (fpu_b),
        .rsp   (fpu_rsp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
                if (start && !undef)
                    state_next = T_SCAN;
            T_SCAN:
                if (n_reg == '0)
                    state_next = T_LEVEL;
            T_LEVEL:
                state_next = (depth_reg == '0) ? T_FINISH : T_WAIT_U;
            T_WAIT_U:
                if (fpu_rsp.done)
                    state_next = T_SQR;
            T_SQR:
                state_next = T_WAIT_F;
            T_WAIT_F:
                if (fpu_rsp.done)
                    state_next = T_LEVEL;
            T_FINISH:
                state_next = (!neg_reg || f_zero) ? T_IDLE : T_WAIT_R;
            T_WAIT_R:
                if (fpu_rsp.done)
                    state_next = T_IDLE;
            default:
                state_next = T_IDLE;
        endcase
    end

    // Unit requests. Each level first forms u = x * f; an even level then
    // squares u, and an odd level multiplies u by the old f.
    always_comb
    begin
        fpu_req.valid = 1'b0;
        fpu_req.op    = FOP_MUL;
        fpu_a         = x_reg;
        fpu_b         = f_reg;
        unique case (state_reg)
            T_LEVEL:
                fpu_req.valid = (depth_reg != '0);
            T_SQR:
            begin
                fpu_req.valid = 1'b1;
                fpu_a         = u_reg;
                fpu_b         = par_reg[0] ? f_reg : u_reg;
            end
            T_FINISH:
            begin
                fpu_req.valid = neg_reg && !f_zero;
                fpu_req.op    = FOP_RECIP;
                fpu_a         = f_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != T_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
            depth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == T_IDLE) && start && undef)
                      || ((state_reg == T_FINISH) && (!neg_reg || f_zero))
                      || ((state_reg == T_WAIT_R) && fpu_rsp.done);
            if ((state_reg == T_SCAN) && (n_reg != '0))
                depth_reg <= depth_reg + DW'(1);
            else if ((state_reg == T_WAIT_F) && fpu_rsp.done)
                depth_reg <= depth_reg - DW'(1);
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            T_IDLE:
                if (start)
                begin
                    x_reg   <= args.base_bits;
                    n_reg   <= mag;
                    neg_reg <= e_neg;
                    f_reg   <= DBL_ONE;
                    res_reg <= '{result_bits: 64'd0, undefined: 1'b1};
                end
            T_SCAN:
                if (n_reg != '0)
                begin
                    par_reg <= {par_reg[EXP_WIDTH-2:0], n_reg[0]};
                    n_reg   <= n_step;
                end
            T_WAIT_U:
                if (fpu_rsp.done)
                    u_reg <= fpu_rsp.bits;
            T_WAIT_F:
                if (fpu_rsp.done)
                begin
                    f_reg   <= fpu_rsp.bits;
                    par_reg <= {1'b0, par_reg[EXP_WIDTH-1:1]};
                end
            T_FINISH:
                if (!neg_reg)
                    res_reg <= '{result_bits: f_reg, undefined: 1'b0};
                else if (f_zero)
                    res_reg <= '{result_bits: {f_reg[63], DBL_EXP_MAX, 52'd0},
                                 undefined: 1'b0};
            T_WAIT_R:
                if (fpu_rsp.done)
                    res_reg <= '{result_bits: fpu_rsp.bits, undefined: 1'b0};
            default:
            begin
            end
        endcase
    end

    // A result beat always follows either an accepted start or busy work.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without a preceding job");

    // The undefined flag always comes with a zero result pattern.
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.undefined) |-> (res.result_bits == 64'd0))
        else $error("undefined result carries a nonzero pattern");

    // Every pushed parity has been consumed once the core is idle.
    a_depth_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_IDLE) |-> (depth_reg == '0))
        else $error("squaring chain left unfinished");

endmodule
